>>> rtl/fcpe_pkg.sv
package fcpe_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int TAG_W    = 64;
  localparam int VAL_W    = 32;
  localparam int CFG_W    = 5;
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP = 2'd0,
    FN_ADD    = 2'd1,
    FN_UPDATE = 2'd2,
    FN_REMOVE = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic search;
    logic apply;
  } dp_cmd_t;

endpackage

>>> rtl/fcpe_ctrl.sv
module fcpe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fcpe_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_APPLY  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = S_APPLY;
      end
      S_APPLY: begin
        // hold until the result register can take the item
        if (out_free) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/fcpe_dp.sv
module fcpe_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fcpe_pkg::dp_cmd_t              cmd_i,
  input  logic                           cfg_we_i,
  input  logic [fcpe_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [fcpe_pkg::FUNC_W-1:0]    func_i,
  input  logic [fcpe_pkg::TAG_W-1:0]     key_tag_i,
  input  logic [fcpe_pkg::VAL_W-1:0]     value_handle_i,
  input  logic                           pin_i,
  output logic [fcpe_pkg::STAT_W-1:0]    status_o,
  output logic [fcpe_pkg::VAL_W-1:0]     found_value_o,
  output logic                           released_o,
  output logic [fcpe_pkg::VAL_W-1:0]     released_value_o,
  output logic [fcpe_pkg::CNT_W-1:0]     occupancy_o
);

  localparam int D  = fcpe_pkg::DEPTH;
  localparam int IW = fcpe_pkg::IDX_W;
  localparam int CW = fcpe_pkg::CNT_W;
  localparam int KW = fcpe_pkg::KEY_BITS;
  localparam int VW = fcpe_pkg::VAL_W;

  // entry cells, oldest in slot 0
  logic [KW-1:0] key_q [D];
  logic [KW-1:0] key_d [D];
  logic [VW-1:0] val_q [D];
  logic [VW-1:0] val_d [D];
  logic          pin_q [D];
  logic          pin_d [D];
  logic [CW-1:0] count_q, count_d;
  logic [fcpe_pkg::CFG_W-1:0] cap_q;

  // latched item
  fcpe_pkg::func_e op_func_q;
  logic [KW-1:0]   op_key_q;
  logic [VW-1:0]   op_val_q;
  logic            op_pin_q;

  // search results
  logic          hit_q, hit_d, evict_q, evict_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, evict_idx_q, evict_idx_d;
  logic [CW-1:0] cap_eff;

  // result register
  fcpe_pkg::status_e stat_q, stat_d;
  logic [VW-1:0]     found_q, found_d, relv_q, relv_d;
  logic              rel_q, rel_d;
  logic [CW-1:0]     occ_q;

  logic          drop_en, wr_en;
  logic [IW-1:0] drop_idx, rd_idx;
  logic [CW-1:0] cnt_after;
  logic [VW-1:0] rd_val;

  always_comb begin
    if (int'(cap_q) > D) begin
      cap_eff = CW'(D);
    end else if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  // oldest match, and oldest unpinned entry when at capacity; scan downward so the lowest slot wins
  always_comb begin
    hit_d       = 1'b0;
    hit_idx_d   = '0;
    evict_d     = 1'b0;
    evict_idx_d = '0;
    for (int j = D - 1; j >= 0; j--) begin
      if (CW'(j) < count_q && key_q[j] == op_key_q) begin
        hit_d     = 1'b1;
        hit_idx_d = IW'(j);
      end
      if (CW'(j) < count_q && !pin_q[j] && count_q >= cap_eff) begin
        evict_d     = 1'b1;
        evict_idx_d = IW'(j);
      end
    end
  end

  assign rd_idx = (op_func_q == fcpe_pkg::FN_ADD) ? evict_idx_q : hit_idx_q;
  assign rd_val = val_q[rd_idx];

  always_comb begin
    key_d     = key_q;
    val_d     = val_q;
    pin_d     = pin_q;
    count_d   = count_q;
    stat_d    = fcpe_pkg::ST_OK;
    found_d   = '0;
    rel_d     = 1'b0;
    relv_d    = '0;
    drop_en   = 1'b0;
    drop_idx  = hit_idx_q;
    wr_en     = 1'b0;
    cnt_after = count_q;
    unique case (op_func_q)
      fcpe_pkg::FN_LOOKUP: begin
        if (hit_q) begin
          found_d = rd_val;
        end else begin
          stat_d = fcpe_pkg::ST_MISS;
        end
      end
      fcpe_pkg::FN_ADD: begin
        drop_en   = evict_q;
        drop_idx  = evict_idx_q;
        rel_d     = evict_q;
        relv_d    = evict_q ? rd_val : '0;
        cnt_after = count_q - CW'(evict_q);
        if (cnt_after == CW'(D)) begin
          stat_d = fcpe_pkg::ST_FULL;
        end else begin
          wr_en = 1'b1;
        end
      end
      fcpe_pkg::FN_UPDATE: begin
        if (hit_q) begin
          rel_d            = 1'b1;
          relv_d           = rd_val;
          val_d[hit_idx_q] = op_val_q;
        end else begin
          stat_d = fcpe_pkg::ST_MISS;
        end
      end
      fcpe_pkg::FN_REMOVE: begin
        if (hit_q) begin
          rel_d     = 1'b1;
          relv_d    = rd_val;
          drop_en   = 1'b1;
          cnt_after = count_q - CW'(1);
        end else begin
          stat_d = fcpe_pkg::ST_MISS;
        end
      end
      default: begin
        stat_d = fcpe_pkg::ST_MISS;
      end
    endcase

    // close the gap: every slot at or above the dropped one, but the top slot, takes its upper neighbor
    if (drop_en) begin
      for (int j = 0; j < D - 1; j++) begin
        if (IW'(j) >= drop_idx) begin
          key_d[j] = key_q[j+1];
          val_d[j] = val_q[j+1];
          pin_d[j] = pin_q[j+1];
        end
      end
      count_d = cnt_after;
    end

    if (wr_en) begin
      key_d[cnt_after[IW-1:0]] = op_key_q;
      val_d[cnt_after[IW-1:0]] = op_val_q;
      pin_d[cnt_after[IW-1:0]] = op_pin_q;
      count_d                  = cnt_after + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= fcpe_pkg::CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.apply) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_func_q <= fcpe_pkg::func_e'(func_i);
      op_key_q  <= key_tag_i[KW-1:0];
      op_val_q  <= value_handle_i;
      op_pin_q  <= pin_i;
    end
    if (cmd_i.search) begin
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      evict_q     <= evict_d;
      evict_idx_q <= evict_idx_d;
    end
    if (cmd_i.apply) begin
      key_q  <= key_d;
      val_q  <= val_d;
      pin_q  <= pin_d;
      stat_q <= stat_d;
      found_q <= found_d;
      rel_q  <= rel_d;
      relv_q <= relv_d;
      occ_q  <= count_d;
    end
  end

  assign status_o         = stat_q;
  assign found_value_o    = found_q;
  assign released_o       = rel_q;
  assign released_value_o = relv_q;
  assign occupancy_o      = occ_q;

endmodule

>>> rtl/fifo_cache_with_pinned_entries.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  func_i, key_tag_i, value_handle_i, pin_i
// out       output     out_valid_o / out_stall_i status_o, found_value_o, released_o,
//                                               released_value_o, occupancy_o
// cfg       input      cfg_we_i                 cfg_wdata_i (capacity)
//
// An item goes through accept, a registered compare of the key against all
// 16 cells with priority pick, then one update step that shifts the cells and
// loads the result register. The next item is accepted in the cycle after that.
// Reset clears the entry count and sets capacity to 16; no clearing pass.
// A stalled result holds the update step until the result register frees up.
module fifo_cache_with_pinned_entries (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcpe_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fcpe_pkg::FUNC_W-1:0]    func_i,
  input  logic [fcpe_pkg::TAG_W-1:0]     key_tag_i,
  input  logic [fcpe_pkg::VAL_W-1:0]     value_handle_i,
  input  logic                           pin_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fcpe_pkg::STAT_W-1:0]    status_o,
  output logic [fcpe_pkg::VAL_W-1:0]     found_value_o,
  output logic                           released_o,
  output logic [fcpe_pkg::VAL_W-1:0]     released_value_o,
  output logic [fcpe_pkg::CNT_W-1:0]     occupancy_o
);

  fcpe_pkg::dp_cmd_t cmd;

  fcpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  fcpe_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .key_tag_i       (key_tag_i),
    .value_handle_i  (value_handle_i),
    .pin_i           (pin_i),
    .status_o        (status_o),
    .found_value_o   (found_value_o),
    .released_o      (released_o),
    .released_value_o(released_value_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

>>> rtl/fcpe_chk.sv
module fcpe_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [fcpe_pkg::STAT_W-1:0]    status_o,
  input logic [fcpe_pkg::VAL_W-1:0]     found_value_o,
  input logic                           released_o,
  input logic [fcpe_pkg::VAL_W-1:0]     released_value_o,
  input logic [fcpe_pkg::CNT_W-1:0]     occupancy_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(released_value_o) && $stable(occupancy_o))
    else $error("stalled result changed");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= fcpe_pkg::CNT_W'(fcpe_pkg::DEPTH))
    else $error("occupancy above depth");

  a_full_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == fcpe_pkg::ST_FULL |->
      !released_o && occupancy_o == fcpe_pkg::CNT_W'(fcpe_pkg::DEPTH))
    else $error("refused add released a handle or store not full");

  a_rel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !released_o |-> released_value_o == '0)
    else $error("released value without release");

  a_found_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_value_o != '0 |-> status_o == fcpe_pkg::ST_OK && !released_o)
    else $error("found value on a miss or with a release");

endmodule

bind fifo_cache_with_pinned_entries fcpe_chk u_fcpe_chk (.*);

>>> sim/tb_top.sv
module tb_top;
  import fcpe_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] found;
    logic             released;
    logic [VAL_W-1:0] rel_val;
    logic [CNT_W-1:0] occ;
  } cache_resp_t;

  typedef enum logic {ROW_OP, ROW_CAP} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    func_e            fn;
    logic [TAG_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic             pin;
    logic [CFG_W-1:0] cap;
    logic             typed;
    cache_resp_t      resp;
  } stim_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] cap;
    logic [15:0]      n_items;
    logic [7:0]       add_pct;
    logic [7:0]       pin_pct;
  } rand_phase_t;

  localparam logic [TAG_W-1:0] KEY_MASK = (TAG_W'(1) << KEY_BITS) - TAG_W'(1);

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [FUNC_W-1:0] func_i;
  logic [TAG_W-1:0] key_tag_i;
  logic [VAL_W-1:0] value_handle_i;
  logic             pin_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [STAT_W-1:0] status_o;
  logic [VAL_W-1:0] found_value_o;
  logic             released_o;
  logic [VAL_W-1:0] released_value_o;
  logic [CNT_W-1:0] occupancy_o;

  // shadow copy of the table, oldest entry at index 0
  logic [TAG_W-1:0] ent_key [DEPTH];
  logic [VAL_W-1:0] ent_val [DEPTH];
  logic             ent_pin [DEPTH];
  int               ent_cnt;
  logic [CFG_W-1:0] cap_reg;

  cache_resp_t      pending_resp [$];
  stim_row_t        dir_rows [$];
  rand_phase_t      phases [$];
  logic [TAG_W-1:0] key_pool [8];
  int               mismatch_cnt = 0;
  int               resp_cnt = 0;
  bit               no_idle = 1'b0;

  fifo_cache_with_pinned_entries i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .key_tag_i        (key_tag_i),
    .value_handle_i   (value_handle_i),
    .pin_i            (pin_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_value_o    (found_value_o),
    .released_o       (released_o),
    .released_value_o (released_value_o),
    .occupancy_o      (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // close the gap left by entry idx
  function automatic void squeeze_out(int idx);
    for (int i = idx; i + 1 < ent_cnt; i++) begin
      ent_key[i] = ent_key[i+1];
      ent_val[i] = ent_val[i+1];
      ent_pin[i] = ent_pin[i+1];
    end
    ent_cnt--;
  endfunction

  function automatic cache_resp_t apply_cache_op(func_e fn, logic [TAG_W-1:0] key_in,
                                                 logic [VAL_W-1:0] val, logic pin);
    cache_resp_t      r;
    logic [TAG_W-1:0] key;
    int               lim;
    int               hit;
    int               victim;
    key = key_in & KEY_MASK;
    lim = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
    r = '0;
    r.status = ST_OK;
    hit = -1;
    victim = -1;
    // scan downward so the oldest match wins
    for (int i = ent_cnt - 1; i >= 0; i--) begin
      if (ent_key[i] == key) hit = i;
    end
    case (fn)
      FN_LOOKUP: begin
        if (hit < 0) r.status = ST_MISS;
        else r.found = ent_val[hit];
      end
      FN_ADD: begin
        if (ent_cnt >= lim) begin
          for (int i = ent_cnt - 1; i >= 0; i--) begin
            if (!ent_pin[i]) victim = i;
          end
        end
        if (victim >= 0) begin
          r.released = 1'b1;
          r.rel_val  = ent_val[victim];
          squeeze_out(victim);
        end
        if (ent_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ent_key[ent_cnt] = key;
          ent_val[ent_cnt] = val;
          ent_pin[ent_cnt] = pin;
          ent_cnt++;
        end
      end
      FN_UPDATE: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.released = 1'b1;
          r.rel_val  = ent_val[hit];
          ent_val[hit] = val;
        end
      end
      default: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.released = 1'b1;
          r.rel_val  = ent_val[hit];
          squeeze_out(hit);
        end
      end
    endcase
    r.occ = CNT_W'(ent_cnt);
    return r;
  endfunction

  task automatic offer_item(stim_row_t row);
    cache_resp_t pred;
    if (!no_idle && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= row.fn;
    key_tag_i      <= row.key;
    value_handle_i <= row.val;
    pin_i          <= row.pin;
    do @(posedge clk_i); while (in_stall_o);
    pred = apply_cache_op(row.fn, row.key, row.val, row.pin);
    pending_resp.push_back(row.typed ? row.resp : pred);
  endtask

  // write only once the block has drained
  task automatic write_capacity(logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = v;
  endtask

  task automatic check_response();
    cache_resp_t want;
    resp_cnt++;
    if (pending_resp.size() == 0) begin
      $error("unexpected result: status %0d occupancy %0d", status_o, occupancy_o);
      mismatch_cnt++;
    end else begin
      want = pending_resp.pop_front();
      if (status_o !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status_o);
        mismatch_cnt++;
      end
      if (found_value_o !== want.found) begin
        $error("found_value: expected %h, got %h", want.found, found_value_o);
        mismatch_cnt++;
      end
      if (released_o !== want.released) begin
        $error("released: expected %0d, got %0d", want.released, released_o);
        mismatch_cnt++;
      end
      if (released_value_o !== want.rel_val) begin
        $error("released_value: expected %h, got %h", want.rel_val, released_value_o);
        mismatch_cnt++;
      end
      if (occupancy_o !== want.occ) begin
        $error("occupancy: expected %0d, got %0d", want.occ, occupancy_o);
        mismatch_cnt++;
      end
    end
  endtask

  initial begin : result_sink
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) check_response();
      // one long hold-off so the block backs up into its input
      if (!held && resp_cnt == 240) begin
        held = 1'b1;
        stall_left = 90;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 10) begin
        stall_left = $urandom_range(1, 12);
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    #3_000_000;
    $display("fifo_cache_with_pinned_entries: mismatch");
    $finish;
  end

  initial begin
    stim_row_t   row;
    rand_phase_t ph;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    func_i         <= FN_LOOKUP;
    key_tag_i      <= '0;
    value_handle_i <= '0;
    pin_i          <= 1'b0;
    ent_cnt = 0;
    cap_reg = CAP_RESET;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < 8; k++) key_pool[k] = {$urandom(), $urandom()};

    dir_rows.push_back('{ROW_OP, FN_LOOKUP, '0, '0, 1'b0, '0, 1'b1,
                         '{ST_MISS, '0, 1'b0, '0, 5'd0}});
    dir_rows.push_back('{ROW_OP, FN_UPDATE, 64'd5, 32'd9, 1'b0, '0, 1'b1,
                         '{ST_MISS, '0, 1'b0, '0, 5'd0}});
    dir_rows.push_back('{ROW_OP, FN_REMOVE, 64'd5, '0, 1'b0, '0, 1'b1,
                         '{ST_MISS, '0, 1'b0, '0, 5'd0}});
    dir_rows.push_back('{ROW_OP, FN_ADD, '0, '0, 1'b0, '0, 1'b1,
                         '{ST_OK, '0, 1'b0, '0, 5'd1}});
    dir_rows.push_back('{ROW_OP, FN_ADD, '1, '1, 1'b1, '0, 1'b1,
                         '{ST_OK, '0, 1'b0, '0, 5'd2}});
    dir_rows.push_back('{ROW_OP, FN_LOOKUP, '1, '0, 1'b0, '0, 1'b1,
                         '{ST_OK, 32'hFFFF_FFFF, 1'b0, '0, 5'd2}});
    // duplicate key: lookup, update and remove all hit the older copy
    dir_rows.push_back('{ROW_OP, FN_ADD, '0, 32'h0000_1111, 1'b0, '0, 1'b1,
                         '{ST_OK, '0, 1'b0, '0, 5'd3}});
    dir_rows.push_back('{ROW_OP, FN_LOOKUP, '0, '0, 1'b0, '0, 1'b1,
                         '{ST_OK, '0, 1'b0, '0, 5'd3}});
    dir_rows.push_back('{ROW_OP, FN_UPDATE, '0, 32'hA5A5_A5A5, 1'b0, '0, 1'b1,
                         '{ST_OK, '0, 1'b1, '0, 5'd3}});
    dir_rows.push_back('{ROW_OP, FN_REMOVE, '0, '0, 1'b0, '0, 1'b1,
                         '{ST_OK, '0, 1'b1, 32'hA5A5_A5A5, 5'd2}});
    dir_rows.push_back('{ROW_OP, FN_LOOKUP, '0, '0, 1'b0, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_ADD, 64'h5555_5555_5555_5555, 32'h5555_5555, 1'b0,
                         '0, 1'b0, '0});
    // capacity dropped below the count
    dir_rows.push_back('{ROW_CAP, FN_LOOKUP, '0, '0, 1'b0, 5'd2, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0,
                         '0, 1'b0, '0});
    dir_rows.push_back('{ROW_CAP, FN_LOOKUP, '0, '0, 1'b0, 5'd0, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_ADD, 64'd7, 32'd7, 1'b1, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_CAP, FN_LOOKUP, '0, '0, 1'b0, 5'd31, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_ADD, 64'd8, 32'd8, 1'b0, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, 1'b0, '0, 1'b0,
                         '0});
    dir_rows.push_back('{ROW_OP, FN_REMOVE, '1, '0, 1'b0, '0, 1'b0, '0});
    // capacity 1: pinned adds evict the unpinned ones, then pile up past capacity
    dir_rows.push_back('{ROW_CAP, FN_LOOKUP, '0, '0, 1'b0, 5'd1, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_ADD, 64'd9, 32'd9, 1'b1, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_ADD, 64'd10, 32'd10, 1'b1, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_ADD, 64'd11, 32'd11, 1'b1, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_UPDATE, 64'd7, 32'h7777_7777, 1'b0, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_OP, FN_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0, '0, 1'b0,
                         '0});

    // capacity, items, add percent, pin percent
    phases.push_back('{5'd16, 16'd130, 8'd70, 8'd90});
    phases.push_back('{5'd4,  16'd130, 8'd20, 8'd20});
    phases.push_back('{5'd0,  16'd100, 8'd50, 8'd10});
    phases.push_back('{5'd31, 16'd130, 8'd50, 8'd50});
    phases.push_back('{5'd1,  16'd100, 8'd45, 8'd30});
    phases.push_back('{5'd9,  16'd130, 8'd45, 8'd40});
    phases.push_back('{5'd16, 16'd180, 8'd60, 8'd85});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CAP) write_capacity(dir_rows[r].cap);
      else offer_item(dir_rows[r]);
    end

    for (int p = 0; p < phases.size(); p++) begin
      ph = phases[p];
      write_capacity(ph.cap);
      no_idle = (p == phases.size() - 1);
      repeat (ph.n_items) begin
        row = '0;
        row.kind = ROW_OP;
        if ($urandom_range(0, 99) < ph.add_pct) begin
          row.fn = FN_ADD;
        end else begin
          case ($urandom_range(0, 2))
            0:       row.fn = FN_LOOKUP;
            1:       row.fn = FN_UPDATE;
            default: row.fn = FN_REMOVE;
          endcase
        end
        // mostly reuse a small key set so operations hit
        if ($urandom_range(0, 99) < 5) key_pool[$urandom_range(0, 7)] = {$urandom(), $urandom()};
        if ($urandom_range(0, 99) < 80) row.key = key_pool[$urandom_range(0, 7)];
        else row.key = {$urandom(), $urandom()};
        row.val = $urandom();
        row.pin = ($urandom_range(0, 99) < ph.pin_pct);
        offer_item(row);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("fifo_cache_with_pinned_entries: match");
    end else begin
      $display("fifo_cache_with_pinned_entries: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fcpe_pkg.sv
rtl/fcpe_ctrl.sv
rtl/fcpe_dp.sv
rtl/fifo_cache_with_pinned_entries.sv
rtl/fcpe_chk.sv
sim/tb_top.sv
